FILE: hdl/nbt_pkg.sv
// shared types and codes for the node blocklist table
package nbt_pkg;

  // request codes
  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_LOOKUP = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_DROP   = 3'd4;

  // reason codes
  localparam logic [2:0] RSN_DONE     = 3'd0;
  localparam logic [2:0] RSN_PRESENT  = 3'd1;
  localparam logic [2:0] RSN_FULL     = 3'd2;
  localparam logic [2:0] RSN_NOTFOUND = 3'd3;
  localparam logic [2:0] RSN_SRC      = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] key_a;
    logic [15:0] key_b;
    logic        a_present;
    logic        b_present;
  } nbt_req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] reason;
    logic [4:0] entry_count;
  } nbt_res_t;

  typedef enum logic {
    NBT_IDLE,
    NBT_EXEC
  } nbt_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } nbt_cmd_t;

endpackage

FILE: hdl/nbt_ctrl.sv
// request sequencer: accepts a request, then runs the execute state
module nbt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output nbt_pkg::nbt_cmd_t cmd
);
  import nbt_pkg::*;

  nbt_state_t state_r;
  nbt_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NBT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      NBT_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = NBT_EXEC;
        end
      end
      NBT_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = NBT_IDLE;
      end
      default: begin
        state_nxt = NBT_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/nbt_datapath.sv
// entry registers, parallel key compare, table update and result register
module nbt_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nbt_pkg::nbt_cmd_t cmd,
  input  nbt_pkg::nbt_req_t in_req,
  output logic              out_valid,
  output nbt_pkg::nbt_res_t out_res
);
  import nbt_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [15:0]            entry_r [MAX_ENTRIES];
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;

  // captured request and compare results
  logic [2:0]             req_type_r;
  logic [15:0]            key_a_r;
  logic                   ap_r;
  logic                   bp_r;
  logic [MAX_ENTRIES-1:0] ma_r;
  logic [MAX_ENTRIES-1:0] mb_r;
  logic [MAX_ENTRIES-1:0] ma_nxt;
  logic [MAX_ENTRIES-1:0] mb_nxt;
  logic [MAX_ENTRIES-1:0] pre_a;

  logic                   any_a;
  logic                   any_b;
  logic                   full;
  logic                   add_ok;
  logic                   rem_ok;
  logic                   hit_nxt;
  logic [2:0]             reason_nxt;
  logic [CW+4:0]          cnt_ext;

  logic                   out_valid_r;
  nbt_res_t               out_res_r;

  // compare both keys against every valid entry
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cmp
    logic valid;
    assign valid     = CW'(j) < count_r;
    assign ma_nxt[j] = valid && (entry_r[j] == in_req.key_a);
    assign mb_nxt[j] = valid && (entry_r[j] == in_req.key_b);
  end

  // capture the request on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= in_req.req_type;
      key_a_r    <= in_req.key_a;
      ap_r       <= in_req.a_present;
      bp_r       <= in_req.b_present;
      ma_r       <= ma_nxt;
      mb_r       <= mb_nxt;
    end
  end

  assign any_a = |ma_r;
  assign any_b = |mb_r;
  assign full  = (count_r == CW'(MAX_ENTRIES));

  // entries at or above the removed one move down
  assign pre_a[0] = ma_r[0];
  for (genvar j = 1; j < MAX_ENTRIES; j++) begin : g_pre
    assign pre_a[j] = pre_a[j-1] | ma_r[j];
  end

  // request decode and result
  always_comb begin
    hit_nxt    = 1'b0;
    reason_nxt = RSN_DONE;
    count_nxt  = count_r;
    add_ok     = 1'b0;
    rem_ok     = 1'b0;
    unique case (req_type_r)
      REQ_ADD: begin
        if (any_a) begin
          reason_nxt = RSN_PRESENT;
        end else if (full) begin
          reason_nxt = RSN_FULL;
        end else begin
          add_ok    = 1'b1;
          hit_nxt   = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_REMOVE: begin
        if (any_a) begin
          rem_ok    = 1'b1;
          hit_nxt   = 1'b1;
          count_nxt = count_r - CW'(1);
        end else begin
          reason_nxt = RSN_NOTFOUND;
        end
      end
      REQ_LOOKUP: begin
        if (ap_r && any_a) begin
          hit_nxt = 1'b1;
        end else begin
          reason_nxt = RSN_NOTFOUND;
        end
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      REQ_DROP: begin
        if (ap_r && any_a) begin
          hit_nxt = 1'b1;
        end else if (bp_r && any_b) begin
          hit_nxt    = 1'b1;
          reason_nxt = RSN_SRC;
        end else begin
          reason_nxt = RSN_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // table entries: append on add, shift down on remove
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_entry
    if (j < MAX_ENTRIES - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (cmd.exec) begin
          if (add_ok && (count_r == CW'(j))) begin
            entry_r[j] <= key_a_r;
          end else if (rem_ok && pre_a[j]) begin
            entry_r[j] <= entry_r[j+1];
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.exec && add_ok && (count_r == CW'(j))) begin
          entry_r[j] <= key_a_r;
        end
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign cnt_ext = {5'b0, count_nxt};

  // result register and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_res_r.hit         <= hit_nxt;
      out_res_r.reason      <= reason_nxt;
      out_res_r.entry_count <= cnt_ext[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: hdl/node_blocklist_table_unit.sv
// node blocklist table: top level
//
//   channel   ports                       transfer
//   request   start, busy, in_req         start high while busy low
//   result    out_valid, out_res          out_valid high, one cycle
//
// for each request, the transfer cycle compares both keys against
// every valid entry in parallel, the next cycle (busy high) updates the table.
// the result shows in the cycle after that, while the next request may transfer.
// synchronous active-low reset empties the table; entry contents are left as is.
// the result receiver cannot stall; out_valid holds for exactly one cycle.
module node_blocklist_table_unit #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  nbt_pkg::nbt_req_t in_req,
  output logic              out_valid,
  output nbt_pkg::nbt_res_t out_res
);
  import nbt_pkg::*;

  nbt_cmd_t cmd;

  // sequencer
  nbt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // table and compare datapath
  nbt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
